[rtl/rmq_pkg.sv]
// package: payload types and constants for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int MAG_MAX       = 32767;
    localparam int ELEM_W        = 16;
    localparam int LANES         = 4;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r01;
        logic signed [ELEM_W-1:0] r02;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
    } t_rmq_in;

    typedef struct packed {
        logic        [ELEM_W-2:0] quat_w;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
    } t_rmq_out;

endpackage
`default_nettype wire

[rtl/rmq_sqrt_pipe.sv]
// pipelined integer square root of (radicand << FRAC_BITS), one root bit per stage
`default_nettype none
module rmq_sqrt_pipe #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int SW        = 17,
    parameter int RW        = 16
) (
    input  wire logic          i_clk,
    input  wire logic [RW-1:0] i_ld,
    input  wire logic [SW-1:0] i_rad,
    output logic      [RW-1:0] o_root
);

    localparam int NW = 2 * RW;

    logic [RW:0]   r_rem [RW-1];
    logic [NW-1:0] r_n   [RW-1];
    logic [RW-1:0] r_q   [RW];

    genvar j;
    generate
        for (j = 0; j < RW; j++) begin : g_stage
            logic [RW:0]   rem_i;
            logic [RW-1:0] q_i;
            logic [NW-1:0] n_i;
            logic [RW+2:0] rem_x;
            logic [RW+2:0] diff;
            logic [RW-1:0] n_q;

            if (j == 0) begin : g_first
                assign rem_i = '0;
                assign q_i   = '0;
                assign n_i   = NW'(i_rad) << FRAC_BITS;
            end else begin : g_next
                assign rem_i = r_rem[j-1];
                assign q_i   = r_q[j-1];
                assign n_i   = r_n[j-1];
            end

            // trial subtract of (4q + 1) from the shifted remainder
            assign rem_x = {rem_i, n_i[NW-1 -: 2]};
            assign diff  = rem_x - {1'b0, q_i, 2'b01};
            assign n_q   = {q_i[RW-2:0], ~diff[RW+2]};

            always_ff @(posedge i_clk) begin
                if (i_ld[j]) begin
                    r_q[j] <= n_q;
                end
            end

            if (j < RW - 1) begin : g_carry
                logic [RW:0] n_rem;
                assign n_rem = diff[RW+2] ? rem_x[RW:0] : diff[RW:0];
                always_ff @(posedge i_clk) begin
                    if (i_ld[j]) begin
                        r_rem[j] <= n_rem;
                        r_n[j]   <= n_i << 2;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_q[RW-1];

endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix to quaternion, deep pipeline with per-stage valid bits
//
//   channel   direction   handshake            payload
//   matrix    in          i_valid / o_stall    i_data (rmq_pkg::t_rmq_in)
//   quat      out         o_valid / i_stall    o_data (rmq_pkg::t_rmq_out)
//
// one transaction per cycle sustained while the output is not stalled;
// latency is set by the square root, which resolves one root bit per stage
// stage 0 forms the four clamped sums, the last stage halves, saturates and signs
// synchronous reset clears the valid bits only; no clearing pass
// a stage holds only when it is full and the stage after it holds, so bubbles close up
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire rmq_pkg::t_rmq_in i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output rmq_pkg::t_rmq_out     o_data
);

    localparam int SW  = $clog2((2 ** FRAC_BITS) + 3 * 32768 + 1);
    localparam int SSW = SW + 1;
    localparam int RW  = (SW + FRAC_BITS + 1) / 2;
    localparam int NS  = RW + 2;
    localparam int MW  = (RW > rmq_pkg::ELEM_W) ? RW : rmq_pkg::ELEM_W;
    localparam int EW  = rmq_pkg::ELEM_W;
    localparam logic signed [SSW-1:0] ONE_S = SSW'(2 ** FRAC_BITS);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    logic signed [SSW-1:0] sum   [rmq_pkg::LANES];
    logic        [SW-1:0]  r_s   [rmq_pkg::LANES];
    logic        [RW-1:0]  root  [rmq_pkg::LANES];
    logic        [EW-2:0]  mag   [rmq_pkg::LANES];
    logic        [2:0]     r_neg [RW+1];
    logic        [2:0]     n_neg;
    rmq_pkg::t_rmq_out     n_out;
    rmq_pkg::t_rmq_out     r_out;

    // ready chain, output side first
    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: diagonal sums and off-diagonal signs
    always_comb begin
        sum[0] = ONE_S + SSW'(i_data.r00) + SSW'(i_data.r11) + SSW'(i_data.r22);
        sum[1] = ONE_S + SSW'(i_data.r00) - SSW'(i_data.r11) - SSW'(i_data.r22);
        sum[2] = ONE_S - SSW'(i_data.r00) + SSW'(i_data.r11) - SSW'(i_data.r22);
        sum[3] = ONE_S - SSW'(i_data.r00) - SSW'(i_data.r11) + SSW'(i_data.r22);
        n_neg[0] = i_data.r21 < i_data.r12;
        n_neg[1] = i_data.r02 < i_data.r20;
        n_neg[2] = i_data.r10 < i_data.r01;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int l = 0; l < rmq_pkg::LANES; l++) begin
                r_s[l] <= sum[l][SW] ? '0 : sum[l][SW-1:0];
            end
            r_neg[0] <= n_neg;
        end
        for (int k = 1; k <= RW; k++) begin
            if (rdy[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < rmq_pkg::LANES; g++) begin : g_lane
            logic [MW-1:0] half;

            rmq_sqrt_pipe #(
                .FRAC_BITS (FRAC_BITS),
                .SW        (SW),
                .RW        (RW)
            ) u_sqrt (
                .i_clk  (i_clk),
                .i_ld   (rdy[RW:1]),
                .i_rad  (r_s[g]),
                .o_root (root[g])
            );

            assign half   = MW'(root[g]) >> 1;
            assign mag[g] = (half > MW'(rmq_pkg::MAG_MAX)) ? (EW-1)'(rmq_pkg::MAG_MAX)
                                                           : half[EW-2:0];
        end
    endgenerate

    // output stage: apply signs
    always_comb begin
        n_out.quat_w = mag[0];
        n_out.quat_x = r_neg[RW][0] ? -$signed({1'b0, mag[1]}) : $signed({1'b0, mag[1]});
        n_out.quat_y = r_neg[RW][1] ? -$signed({1'b0, mag[2]}) : $signed({1'b0, mag[2]});
        n_out.quat_z = r_neg[RW][2] ? -$signed({1'b0, mag[3]}) : $signed({1'b0, mag[3]});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_data  = r_out;
    assign o_stall = !rdy[0];

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && (&r_vld)) |-> o_stall)
        else $error("full pipeline with held result accepted a transaction");

    a_drain_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_vld) + 1 >= $past($countones(r_vld))))
        else $error("pipeline lost more than one transaction in a cycle");

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.quat_x != 16'sh8000 && o_data.quat_y != 16'sh8000 &&
                     o_data.quat_z != 16'sh8000))
        else $error("signed part exceeds saturated magnitude");
`endif

endmodule
`default_nettype wire

[test/rotation_matrix_to_quaternion_tb.sv]
// testbench: rotation matrix to quaternion block checked against a built-in predictor
`default_nettype none
module rotation_matrix_to_quaternion_tb;

    localparam int  FRAC       = rmq_pkg::FRAC_BITS_DEF;
    localparam int  ONE_Q      = 1 << FRAC;
    localparam int  DRAIN_WAIT = 40;
    localparam int  WDOG_LIMIT = 2000;
    localparam logic signed [15:0] E_MAX  = 16'sh7fff;
    localparam logic signed [15:0] E_MIN  = -16'sh8000;
    localparam logic signed [15:0] E_ONE  = 16'sh4000;
    localparam logic signed [15:0] E_NONE = -16'sh4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    rmq_pkg::t_rmq_in  i_data;
    logic              o_valid;
    logic              i_stall;
    rmq_pkg::t_rmq_out o_data;

    rmq_pkg::t_rmq_out expected_quats[$];
    int       errors;
    int       matrices_sent;
    int       quats_checked;
    int       idle_cycles;
    bit       idle_en;

    rotation_matrix_to_quaternion #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // half of the truncated fixed-point root of a clamped sum, saturated
    function automatic logic [15:0] half_root(input longint s);
        longint unsigned n;
        longint unsigned res;
        longint unsigned bitv;
        if (s < 0) s = 0;
        n    = longint'(s) << FRAC;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        res = res / 2;
        if (res > rmq_pkg::MAG_MAX) res = rmq_pkg::MAG_MAX;
        return res[15:0];
    endfunction

    function automatic logic [15:0] signed_part(input logic [15:0] mag, input longint diff);
        return (diff < 0) ? 16'd0 - mag : mag;
    endfunction

    function automatic rmq_pkg::t_rmq_out predict_quat(input rmq_pkg::t_rmq_in m);
        longint   a00;
        longint   a11;
        longint   a22;
        longint   one_l;
        rmq_pkg::t_rmq_out q;
        logic [15:0] mw;
        a00   = longint'($signed(m.r00));
        a11   = longint'($signed(m.r11));
        a22   = longint'($signed(m.r22));
        one_l = ONE_Q;
        mw       = half_root(one_l + a00 + a11 + a22);
        q.quat_w = mw[14:0];
        q.quat_x = signed_part(half_root(one_l + a00 - a11 - a22),
                               longint'($signed(m.r21)) - longint'($signed(m.r12)));
        q.quat_y = signed_part(half_root(one_l - a00 + a11 - a22),
                               longint'($signed(m.r02)) - longint'($signed(m.r20)));
        q.quat_z = signed_part(half_root(one_l - a00 - a11 + a22),
                               longint'($signed(m.r10)) - longint'($signed(m.r01)));
        return q;
    endfunction

    function automatic rmq_pkg::t_rmq_in make_matrix(
        input logic signed [15:0] a00, input logic signed [15:0] a01,
        input logic signed [15:0] a02, input logic signed [15:0] a10,
        input logic signed [15:0] a11, input logic signed [15:0] a12,
        input logic signed [15:0] a20, input logic signed [15:0] a21,
        input logic signed [15:0] a22);
        rmq_pkg::t_rmq_in m;
        m.r00 = a00; m.r01 = a01; m.r02 = a02;
        m.r10 = a10; m.r11 = a11; m.r12 = a12;
        m.r20 = a20; m.r21 = a21; m.r22 = a22;
        return m;
    endfunction

    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(0, 5))
            0:       return E_MAX;
            1:       return E_MIN;
            2:       return 16'sd0;
            3:       return E_ONE;
            4:       return E_NONE;
            default: return 16'($urandom);
        endcase
    endfunction

    // matrix from a random quaternion, divided by its squared norm, with small noise on the diagonal in some draws
    function automatic rmq_pkg::t_rmq_in random_rotation();
        longint w, x, y, z, n, k;
        rmq_pkg::t_rmq_in m;
        w = int'($urandom_range(0, 2000)) - 1000;
        x = int'($urandom_range(0, 2000)) - 1000;
        y = int'($urandom_range(0, 2000)) - 1000;
        z = int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 5) == 0) x = 0;
        if ($urandom_range(0, 5) == 0) y = 0;
        if ($urandom_range(0, 5) == 0) z = 0;
        if ($urandom_range(0, 9) == 0) w = 0;
        n = w * w + x * x + y * y + z * z;
        if (n == 0) begin
            w = 1;
            n = 1;
        end
        k = 2 * ONE_Q;
        m.r00 = 16'(ONE_Q - k * (y * y + z * z) / n);
        m.r01 = 16'(k * (x * y - z * w) / n);
        m.r02 = 16'(k * (x * z + y * w) / n);
        m.r10 = 16'(k * (x * y + z * w) / n);
        m.r11 = 16'(ONE_Q - k * (x * x + z * z) / n);
        m.r12 = 16'(k * (y * z - x * w) / n);
        m.r20 = 16'(k * (x * z - y * w) / n);
        m.r21 = 16'(k * (y * z + x * w) / n);
        m.r22 = 16'(ONE_Q - k * (x * x + y * y) / n);
        if ($urandom_range(0, 3) == 0) begin
            m.r00 = m.r00 + 16'($urandom_range(0, 6) - 3);
            m.r11 = m.r11 + 16'($urandom_range(0, 6) - 3);
            m.r22 = m.r22 + 16'($urandom_range(0, 6) - 3);
        end
        return m;
    endfunction

    // one matrix transaction; called and returns on a falling edge
    task automatic send_matrix(input rmq_pkg::t_rmq_in m);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_quats.push_back(predict_quat(m));
        matrices_sent++;
        @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_matrix(E_ONE, 0, 0, 0, E_ONE, 0, 0, 0, E_ONE));
        send_matrix(make_matrix(E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX,
                                E_MAX, E_MAX, E_MAX));
        send_matrix(make_matrix(E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN,
                                E_MIN, E_MIN, E_MIN));
        send_matrix(make_matrix(E_MAX, 0, 0, 0, E_MAX, 0, 0, 0, E_MAX));
        send_matrix(make_matrix(E_MIN, 0, 0, 0, E_MIN, 0, 0, 0, E_MIN));
        send_matrix(make_matrix(E_MAX, 0, 0, 0, E_MIN, 0, 0, 0, E_MIN));
        send_matrix(make_matrix(E_MIN, 0, 0, 0, E_MAX, 0, 0, 0, E_MIN));
        send_matrix(make_matrix(E_MIN, 0, 0, 0, E_MIN, 0, 0, 0, E_MAX));
        send_matrix(make_matrix(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                                16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555));
    endtask

    task automatic test_sign_cases();
        // half turns: three of the four radicands are exactly zero
        send_matrix(make_matrix(E_ONE, 0, 0, 0, E_NONE, 0, 0, 0, E_NONE));
        send_matrix(make_matrix(E_NONE, 0, 0, 0, E_ONE, 0, 0, 0, E_NONE));
        send_matrix(make_matrix(E_NONE, 0, 0, 0, E_NONE, 0, 0, 0, E_ONE));
        // quarter turns in both directions about each axis
        send_matrix(make_matrix(0, E_NONE, 0, E_ONE, 0, 0, 0, 0, E_ONE));
        send_matrix(make_matrix(0, E_ONE, 0, E_NONE, 0, 0, 0, 0, E_ONE));
        send_matrix(make_matrix(E_ONE, 0, 0, 0, 0, E_NONE, 0, E_ONE, 0));
        send_matrix(make_matrix(E_ONE, 0, 0, 0, 0, E_ONE, 0, E_NONE, 0));
        send_matrix(make_matrix(0, 0, E_ONE, 0, E_ONE, 0, E_NONE, 0, 0));
        send_matrix(make_matrix(0, 0, E_NONE, 0, E_ONE, 0, E_ONE, 0, 0));
        // extreme differences and equal off-diagonals
        send_matrix(make_matrix(0, E_MAX, E_MIN, E_MAX, 0, E_MIN, E_MAX, E_MAX, 0));
        send_matrix(make_matrix(0, E_MIN, E_MAX, E_MIN, 0, E_MAX, E_MIN, E_MIN, 0));
        send_matrix(make_matrix(0, E_MIN, E_MIN, E_MIN, 0, E_MIN, E_MIN, E_MIN, 0));
        send_matrix(make_matrix(E_MIN, 1, 0, 0, E_MIN, 0, 0, 1, E_MIN));
        send_matrix(make_matrix(E_MAX, 0, 1, 0, E_MIN, 1, 0, 0, E_MIN));
    endtask

    task automatic test_random_rotations(input int count);
        repeat (count) send_matrix(random_rotation());
    endtask

    task automatic test_random_patterns(input int count);
        rmq_pkg::t_rmq_in m;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0) begin
                m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            end else begin
                m = make_matrix(pick_element(), pick_element(), pick_element(),
                                pick_element(), pick_element(), pick_element(),
                                pick_element(), pick_element(), pick_element());
            end
            send_matrix(m);
        end
    endtask

    task automatic test_full_rate(input int count);
        idle_en = 1'b0;
        repeat (count) begin
            if ($urandom_range(0, 2) == 0) send_matrix({$urandom, $urandom, $urandom,
                                                        $urandom, 16'($urandom)});
            else send_matrix(random_rotation());
        end
    endtask

    // output backpressure in random bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        rmq_pkg::t_rmq_out exp_q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_quats.size() == 0) begin
                $display("%0t: quaternion transaction with none expected, actual %h",
                         $time, o_data);
                errors++;
            end else begin
                exp_q = expected_quats.pop_front();
                quats_checked++;
                if (o_data.quat_w !== exp_q.quat_w) begin
                    $display("%0t: quat_w expected %0d actual %0d",
                             $time, exp_q.quat_w, o_data.quat_w);
                    errors++;
                end
                if (o_data.quat_x !== exp_q.quat_x) begin
                    $display("%0t: quat_x expected %0d actual %0d",
                             $time, exp_q.quat_x, o_data.quat_x);
                    errors++;
                end
                if (o_data.quat_y !== exp_q.quat_y) begin
                    $display("%0t: quat_y expected %0d actual %0d",
                             $time, exp_q.quat_y, o_data.quat_y);
                    errors++;
                end
                if (o_data.quat_z !== exp_q.quat_z) begin
                    $display("%0t: quat_z expected %0d actual %0d",
                             $time, exp_q.quat_z, o_data.quat_z);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        matrices_sent = 0;
        idle_en       = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_extremes();
        test_sign_cases();
        test_random_rotations(700);
        test_random_patterns(500);
        test_full_rate(150);

        i_valid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d matrices sent (directed, rotations, raw and extreme patterns)",
                 matrices_sent);
        $display("%0d quaternions compared, %0d mismatches", quats_checked, errors);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
rtl/rmq_pkg.sv
rtl/rmq_sqrt_pipe.sv
rtl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
